[sv/ghbr_pkg.sv]
// ============================================================================
// ghbr_pkg - shared types and constants for the gray histogram bar renderer
// Holds the op codes, the queued command format and the column-to-bin map.
// ============================================================================
package ghbr_pkg;

  localparam int COUNT_WIDTH_DEF = 22;
  localparam int CHART_ROWS      = 512;
  localparam int CHART_COLUMNS   = 768;
  localparam int NUM_BINS        = 256;
  localparam int BIN_W           = 8;
  localparam int ROW_W           = 9;
  localparam int COL_W           = 10;
  localparam int OP_W            = 2;
  localparam int IN_TDATA_W      = 32;
  localparam int QUEUE_DEPTH     = 4;

  // Bin 0 spans four columns, bins 1 to 254 three each, bin 255 the last two.
  localparam int FIRST_BIN_COLS  = 4;
  // x/3 == (x*683)>>11 for any x below 2048.
  localparam int DIV3_MUL        = 683;
  localparam int DIV3_SHIFT      = 11;

  typedef enum logic [OP_W-1:0] {
    OP_ACCUMULATE = 2'd0,
    OP_CLEAR      = 2'd1,
    OP_DRAW       = 2'd2
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [BIN_W-1:0] addr;  // gray value or bin to draw
    logic [ROW_W-1:0] row;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [BIN_W-1:0] column_to_bin(input logic [COL_W-1:0] col);
    logic [COL_W-1:0]   off;
    logic [2*COL_W-1:0] prod;
    logic [BIN_W:0]     bin;
    logic [BIN_W-1:0]   res;
    off  = col - COL_W'(FIRST_BIN_COLS);
    prod = (2*COL_W)'(off) * (2*COL_W)'(DIV3_MUL);
    bin  = (BIN_W+1)'(prod >> DIV3_SHIFT) + (BIN_W+1)'(1);
    if (col >= COL_W'(CHART_COLUMNS)) begin
      res = '1;
    end else if (col < COL_W'(FIRST_BIN_COLS)) begin
      res = '0;
    end else if (bin[BIN_W]) begin
      res = '1;
    end else begin
      res = bin[BIN_W-1:0];
    end
    return res;
  endfunction

endpackage

[sv/ghbr_ram.sv]
// ============================================================================
// ghbr_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; a read of the address being
// written returns the old data.
// ============================================================================
module ghbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/ghbr_fifo.sv]
// ============================================================================
// ghbr_fifo - command queue between front and back
// Small register FIFO; push and pop may happen in the same cycle.
// ============================================================================
module ghbr_fifo #(
  parameter int DEPTH = ghbr_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ghbr_pkg::cmd_t      push_cmd,
  input  logic                pop,
  output ghbr_pkg::cmd_t      head_cmd,
  output ghbr_pkg::q_status_t status
);
  import ghbr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign status.full  = (count_r == CNT_W'(DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_cmd     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[sv/ghbr_front.sv]
// ============================================================================
// ghbr_front - request intake and classification
// Decode the op, map the chart column to its bin and queue the command.
// ============================================================================
module ghbr_front (
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [ghbr_pkg::OP_W-1:0]           in_tuser,
  input  logic [ghbr_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  ghbr_pkg::q_status_t                 status,
  output logic                                push,
  output ghbr_pkg::cmd_t                      push_cmd
);
  import ghbr_pkg::*;

  logic [BIN_W-1:0] gray;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic             keep;

  assign gray = in_tdata[BIN_W-1:0];
  assign row  = in_tdata[BIN_W+ROW_W-1:BIN_W];
  assign col  = in_tdata[BIN_W+ROW_W+COL_W-1:BIN_W+ROW_W];

  assign in_tready = !status.full;

  always_comb begin
    keep          = 1'b1;
    push_cmd.op   = OP_ACCUMULATE;
    push_cmd.addr = gray;
    push_cmd.row  = row;
    case (in_tuser)
      OP_ACCUMULATE: begin
        push_cmd.op   = OP_ACCUMULATE;
        push_cmd.addr = gray;
      end
      OP_CLEAR: begin
        push_cmd.op   = OP_CLEAR;
      end
      OP_DRAW: begin
        push_cmd.op   = OP_DRAW;
        push_cmd.addr = column_to_bin(col);
      end
      default: begin
        // unused code: drop without effect
        keep = 1'b0;
      end
    endcase
  end

  assign push = in_tvalid && in_tready && keep;

endmodule

[sv/ghbr_back.sv]
// ============================================================================
// ghbr_back - histogram store and bar renderer
// Read-modify-write of the bin store with forwarding, peak tracking, clear,
// and a three-stage draw path ending in the output register.
// ============================================================================
module ghbr_back #(
  parameter int COUNT_WIDTH = ghbr_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  ghbr_pkg::cmd_t                            head_cmd,
  input  ghbr_pkg::q_status_t                       status,
  output logic                                      pop,
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  output logic [((16+COUNT_WIDTH+7)/8)*8-1:0]       out_tdata
);
  import ghbr_pkg::*;

  localparam int OUT_W  = ((2*BIN_W + COUNT_WIDTH + 7) / 8) * 8;
  localparam int SCL_W  = (COUNT_WIDTH > ROW_W) ? COUNT_WIDTH - ROW_W + 1 : 1;
  localparam int K_W    = ROW_W + 1;
  localparam int PROD_W = K_W + SCL_W;

  logic adv;

  // RMW stage
  logic                   s2_valid_r, s2_valid_nxt;
  cmd_t                   s2_cmd_r;
  logic [COUNT_WIDTH-1:0] rdata, cur, inc;
  logic [NUM_BINS-1:0]    valid_r, valid_nxt;
  logic [COUNT_WIDTH-1:0] peak_r, peak_nxt;
  logic                   fwd_valid_r, fwd_valid_nxt;
  logic [BIN_W-1:0]       fwd_addr_r, fwd_addr_nxt;
  logic [COUNT_WIDTH-1:0] fwd_data_r, fwd_data_nxt;
  logic                   ram_we;

  // draw stages
  logic                   s3_valid_r, s3_valid_nxt;
  logic [BIN_W-1:0]       s3_bin_r;
  logic [COUNT_WIDTH-1:0] s3_cnt_r;
  logic [K_W-1:0]         s3_k_r;
  logic [SCL_W-1:0]       s3_scale_r;
  logic                   s4_valid_r, s4_valid_nxt;
  logic [BIN_W-1:0]       s4_bin_r;
  logic [COUNT_WIDTH-1:0] s4_cnt_r;
  logic [PROD_W-1:0]      s4_prod_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]       out_data_r, out_data_nxt;
  logic [BIN_W-1:0]       pix;

  assign adv = !out_valid_r || out_tready;
  assign pop = adv && !status.empty;

  ghbr_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (NUM_BINS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s2_cmd_r.addr),
    .wdata (inc),
    .re    (pop),
    .raddr (head_cmd.addr),
    .rdata (rdata)
  );

  // current bin value: last write, else store, else zero if never written
  always_comb begin
    if (fwd_valid_r && fwd_addr_r == s2_cmd_r.addr) begin
      cur = fwd_data_r;
    end else if (valid_r[s2_cmd_r.addr]) begin
      cur = rdata;
    end else begin
      cur = '0;
    end
    inc = (&cur) ? cur : cur + 1'b1;
  end

  always_comb begin
    ram_we        = 1'b0;
    valid_nxt     = valid_r;
    peak_nxt      = peak_r;
    fwd_valid_nxt = fwd_valid_r;
    fwd_addr_nxt  = fwd_addr_r;
    fwd_data_nxt  = fwd_data_r;
    if (adv && s2_valid_r) begin
      case (s2_cmd_r.op)
        OP_ACCUMULATE: begin
          ram_we                   = 1'b1;
          valid_nxt[s2_cmd_r.addr] = 1'b1;
          fwd_valid_nxt            = 1'b1;
          fwd_addr_nxt             = s2_cmd_r.addr;
          fwd_data_nxt             = inc;
          if (inc > peak_r) begin
            peak_nxt = inc;
          end
        end
        OP_CLEAR: begin
          valid_nxt     = '0;
          peak_nxt      = '0;
          fwd_valid_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // pipeline valids
  always_comb begin
    s2_valid_nxt  = s2_valid_r;
    s3_valid_nxt  = s3_valid_r;
    s4_valid_nxt  = s4_valid_r;
    out_valid_nxt = out_valid_r;
    if (adv) begin
      s2_valid_nxt  = pop;
      s3_valid_nxt  = s2_valid_r && (s2_cmd_r.op == OP_DRAW);
      s4_valid_nxt  = s3_valid_r;
      out_valid_nxt = s4_valid_r;
    end
  end

  // bar test: count/scale >= rows-row  <=>  count >= (rows-row)*scale
  always_comb begin
    pix          = (PROD_W'(s4_cnt_r) >= s4_prod_r) ? s4_bin_r : ~s4_bin_r;
    out_data_nxt = OUT_W'({s4_cnt_r, s4_bin_r, pix});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      peak_r      <= '0;
      fwd_valid_r <= 1'b0;
    end else begin
      s2_valid_r  <= s2_valid_nxt;
      s3_valid_r  <= s3_valid_nxt;
      s4_valid_r  <= s4_valid_nxt;
      out_valid_r <= out_valid_nxt;
      valid_r     <= valid_nxt;
      peak_r      <= peak_nxt;
      fwd_valid_r <= fwd_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr_r <= fwd_addr_nxt;
    fwd_data_r <= fwd_data_nxt;
    if (adv) begin
      s2_cmd_r   <= head_cmd;
      s3_bin_r   <= s2_cmd_r.addr;
      s3_cnt_r   <= cur;
      s3_k_r     <= K_W'(CHART_ROWS) - K_W'(s2_cmd_r.row);
      s3_scale_r <= SCL_W'(peak_r >> ROW_W) + SCL_W'(1);
      s4_bin_r   <= s3_bin_r;
      s4_cnt_r   <= s3_cnt_r;
      s4_prod_r  <= PROD_W'(s3_k_r) * PROD_W'(s3_scale_r);
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[sv/gray_histogram_bar_render.sv]
// ============================================================================
// gray_histogram_bar_render - 256-bin gray histogram with bar-chart readout
// Counts 8-bit pixels into saturating bins and draws a 512x768 bar chart.
// ============================================================================
// Usage
//   Input stream: in_tuser carries the op (accumulate, clear, draw); in_tdata
//   carries gray_value, chart_row and chart_column. Accumulate and clear
//   produce nothing on the output; a draw request returns one result on the
//   output stream with the drawn pixel, the bin shown at the column and that
//   bin's count. The unused op code is dropped at the input.
//   Throughput: one request per cycle of any kind while the output is free,
//   set by the single bin store read-modify-write; back-to-back hits on the
//   same bin are forwarded. Draw path: queue, store read, row-distance and
//   scale register, multiply, then compare/output register.
//   Reset: synchronous, active low; all bins and the peak read as zero at
//   once (per-bin valid bits), so no clearing pass is needed. A clear request
//   works the same way.
//   Stall: while the output holds an untaken result the whole execution pipe
//   holds; the 4-entry request queue then fills and in_tready drops.
// ============================================================================
module gray_histogram_bar_render #(
  parameter int COUNT_WIDTH = ghbr_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // request channel
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [ghbr_pkg::OP_W-1:0]             in_tuser,  // [1:0] op
  // [7:0] gray_value, [16:8] chart_row, [26:17] chart_column, rest zero
  input  logic [ghbr_pkg::IN_TDATA_W-1:0]       in_tdata,
  // result channel
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [7:0] chart_pixel, [15:8] bin_index, then bin_count, rest zero
  output logic [((16+COUNT_WIDTH+7)/8)*8-1:0]   out_tdata
);
  import ghbr_pkg::*;

  // queue handshake between intake and execution
  logic      q_push;
  cmd_t      q_push_cmd;
  logic      q_pop;
  cmd_t      q_head;
  q_status_t q_status;

  // decode requests and map columns to bins
  ghbr_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .status    (q_status),
    .push      (q_push),
    .push_cmd  (q_push_cmd)
  );

  // decouple intake from execution stalls
  ghbr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .pop      (q_pop),
    .head_cmd (q_head),
    .status   (q_status)
  );

  // update bins, track the peak, render chart pixels
  ghbr_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_cmd   (q_head),
    .status     (q_status),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // never pop an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_status.empty)
    else $error("request queue popped while empty");

  // never push into a full queue
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_status.full)
    else $error("request queue pushed while full");

  // a request taken while nothing pops leaves the queue nonempty
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && !q_pop) |=> !q_status.empty)
    else $error("accepted request lost from queue");

endmodule
